FILE: rtl/rufp_pkg.sv
// ----------------------------------------------------------------------------
// rufp_pkg
// Shared types, constants and helpers for the radar serial frame parser.
// ----------------------------------------------------------------------------
package rufp_pkg;

  // Header and tail bytes
  localparam logic [7:0] HdrShort0 = 8'hFD;
  localparam logic [7:0] HdrShort1 = 8'hF8;
  localparam logic [7:0] HdrLong0  = 8'hAA;
  localparam logic [7:0] HdrLong1  = 8'hFF;
  localparam logic [7:0] HdrLong2  = 8'h03;
  localparam logic [7:0] HdrLong3  = 8'h00;
  localparam logic [7:0] TailLong0 = 8'h55;
  localparam logic [7:0] TailLong1 = 8'hCC;
  localparam int unsigned StatusTargetBit = 6;  // mask 0x40

  // Payload lengths in bytes
  localparam int unsigned ShortLen = 9;
  localparam int unsigned LongLen  = 26;
  localparam int unsigned IdxW     = 5;

  // Register reset values and indexes
  localparam logic [15:0] SignalBaseRst = 16'd2056;
  localparam logic [15:0] SignalTolRst  = 16'd12;
  localparam logic [15:0] OriginXRst    = 16'd2056;
  localparam logic [15:0] OriginYRst    = 16'd3080;

  localparam logic [1:0] RegSignalBase = 2'd0;
  localparam logic [1:0] RegSignalTol  = 2'd1;
  localparam logic [1:0] RegOriginX    = 2'd2;
  localparam logic [1:0] RegOriginY    = 2'd3;

  localparam logic FrameShort = 1'b0;
  localparam logic FrameLong  = 1'b1;

  typedef struct packed {
    logic               frame_kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] speed_tenths;
    logic               detected;
  } result_t;

  typedef struct packed {
    logic [15:0] signal_base;
    logic [15:0] signal_tolerance;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } cfg_t;

  // |w - base| <= tol
  function automatic logic within_tol(input logic [15:0] w, input logic [15:0] base,
                                      input logic [15:0] tol);
    logic [16:0] d;
    logic [16:0] mag;
    d   = {1'b0, w} - {1'b0, base};
    mag = d[16] ? (17'd0 - d) : d;
    return mag <= {1'b0, tol};
  endfunction

  // Sign-magnitude (bit 15 sign) to two's complement; negative zero gives 0.
  function automatic logic [15:0] sm_to_twos(input logic [15:0] v);
    logic [15:0] mag;
    mag = {1'b0, v[14:0]};
    return v[15] ? (16'd0 - mag) : mag;
  endfunction

endpackage

FILE: rtl/radar_uart_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// radar_uart_frame_parser_unit
// Byte-stream parser for short (FD F8) and long (AA FF 03 00) radar frames.
// ----------------------------------------------------------------------------
// One received byte is taken per transfer, one per clock when the stream
// allows. Headers are recognized only while seeking a header; a short frame
// then collects 9 payload bytes (status plus four little-endian words), a
// long frame 26 bytes ending in 55 CC. The transfer carrying a frame's last
// byte is evaluated in the same cycle and, if the frame passes its checks,
// yields one result in the output register on the next clock. The output
// register decouples the two sides: while a result waits, bytes that do
// not close a frame are still taken; only a closing byte stalls, and only
// while the output register is full and held. Configuration registers are
// plain writes and should change only while no frame is in flight.
// ----------------------------------------------------------------------------
module radar_uart_frame_parser_unit (
  input  logic               clk,
  input  logic               rst,
  // byte input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               frame_kind,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] speed_tenths,
  output logic               detected,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Parser modes
  localparam logic [1:0] ModeSync  = 2'd0;
  localparam logic [1:0] ModeShort = 2'd1;
  localparam logic [1:0] ModeLong  = 2'd2;

  localparam logic [rufp_pkg::IdxW-1:0] ShortLast = rufp_pkg::IdxW'(rufp_pkg::ShortLen - 1);
  localparam logic [rufp_pkg::IdxW-1:0] LongLast  = rufp_pkg::IdxW'(rufp_pkg::LongLen - 1);
  localparam logic [rufp_pkg::IdxW-1:0] TailIdx   = rufp_pkg::IdxW'(rufp_pkg::LongLen - 2);

  rufp_pkg::cfg_t cfg;

  logic [1:0]                  parse_mode, parse_mode_next;
  logic [rufp_pkg::IdxW-1:0]   payload_index, payload_index_next;
  logic [7:0]                  hist [3];
  logic [7:0]                  pay [9];
  logic [7:0]                  pay24;

  logic                        accept;
  logic                        closing;
  logic                        fd_hdr, aa_hdr;
  logic                        eval_ok;
  rufp_pkg::result_t           eval_res;
  rufp_pkg::result_t           res_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.signal_base      <= rufp_pkg::SignalBaseRst;
      cfg.signal_tolerance <= rufp_pkg::SignalTolRst;
      cfg.origin_x         <= rufp_pkg::OriginXRst;
      cfg.origin_y         <= rufp_pkg::OriginYRst;
    end else if (cfg_we) begin
      case (cfg_index)
        rufp_pkg::RegSignalBase: cfg.signal_base      <= cfg_data;
        rufp_pkg::RegSignalTol:  cfg.signal_tolerance <= cfg_data;
        rufp_pkg::RegOriginX:    cfg.origin_x         <= cfg_data;
        rufp_pkg::RegOriginY:    cfg.origin_y         <= cfg_data;
        default: ;
      endcase
    end
  end

  // The next byte closes a frame: decided by state alone, so stall never
  // looks at the incoming valid or data.
  assign closing = ((parse_mode == ModeShort) && (payload_index == ShortLast)) ||
                   ((parse_mode == ModeLong)  && (payload_index == LongLast));

  assign in_stall = closing & out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Header match against up to three previous bytes
  assign fd_hdr = (hist[2] == rufp_pkg::HdrShort0) && (rx_byte == rufp_pkg::HdrShort1);
  assign aa_hdr = (hist[0] == rufp_pkg::HdrLong0) && (hist[1] == rufp_pkg::HdrLong1) &&
                  (hist[2] == rufp_pkg::HdrLong2) && (rx_byte == rufp_pkg::HdrLong3);

  always_comb begin
    parse_mode_next    = parse_mode;
    payload_index_next = payload_index;
    case (parse_mode)
      ModeShort, ModeLong: begin
        if (closing) begin
          parse_mode_next    = ModeSync;
          payload_index_next = '0;
        end else begin
          payload_index_next = payload_index + 1'b1;
        end
      end
      default: begin
        // sync, and the unused code behaves the same
        payload_index_next = '0;
        if (fd_hdr)      parse_mode_next = ModeShort;
        else if (aa_hdr) parse_mode_next = ModeLong;
        else             parse_mode_next = ModeSync;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode    <= ModeSync;
      payload_index <= '0;
      hist[0]       <= '0;
      hist[1]       <= '0;
      hist[2]       <= '0;
    end else if (accept) begin
      parse_mode    <= parse_mode_next;
      payload_index <= payload_index_next;
      hist[0]       <= hist[1];
      hist[1]       <= hist[2];
      hist[2]       <= rx_byte;
    end
  end

  // Payload capture: bytes at these indexes are kept
  // (0..8 for both kinds, plus the first tail byte of a long frame).
  always_ff @(posedge clk) begin
    if (accept && (parse_mode == ModeShort || parse_mode == ModeLong)) begin
      for (int k = 0; k < 9; k++) begin
        if (payload_index == rufp_pkg::IdxW'(k)) pay[k] <= rx_byte;
      end
      if (payload_index == TailIdx) pay24 <= rx_byte;
    end
  end

  rufp_frame_eval u_eval (
    .kind      (parse_mode == ModeLong),
    .pay       (pay),
    .pay24     (pay24),
    .last_byte (rx_byte),
    .cfg       (cfg),
    .ok        (eval_ok),
    .res       (eval_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && closing && eval_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && closing && eval_ok) begin
      res_q <= eval_res;
    end
  end

  assign frame_kind   = res_q.frame_kind;
  assign pos_x        = res_q.pos_x;
  assign pos_y        = res_q.pos_y;
  assign speed_tenths = res_q.speed_tenths;
  assign detected     = res_q.detected;

endmodule

FILE: rtl/rufp_frame_eval.sv
// ----------------------------------------------------------------------------
// rufp_frame_eval
// Checks a completed frame and forms its result fields.
// ----------------------------------------------------------------------------
module rufp_frame_eval (
  input  logic                kind,        // frame being closed
  input  logic [7:0]          pay [9],     // payload bytes 0..8
  input  logic [7:0]          pay24,       // long-frame byte 24
  input  logic [7:0]          last_byte,   // byte closing the frame
  input  rufp_pkg::cfg_t      cfg,
  output logic                ok,
  output rufp_pkg::result_t   res
);

  logic [15:0] w1, w2, w3, w4;
  logic [15:0] lx, ly, ls;
  logic        short_ok, long_ok;

  // Short frame: status in byte 0, words at 1, 3, 5, 7 (w4 high byte arrives last)
  assign w1 = {pay[2], pay[1]};
  assign w2 = {pay[4], pay[3]};
  assign w3 = {pay[6], pay[5]};
  assign w4 = {last_byte, pay[7]};

  assign short_ok = pay[0][rufp_pkg::StatusTargetBit]
                  & rufp_pkg::within_tol(w3, cfg.signal_base, cfg.signal_tolerance)
                  & rufp_pkg::within_tol(w4, cfg.signal_base, cfg.signal_tolerance);

  // Long frame: words at 0, 2, 4; tail at 24, 25
  assign lx = rufp_pkg::sm_to_twos({pay[1], pay[0]});
  assign ly = rufp_pkg::sm_to_twos({pay[3], pay[2]});
  assign ls = rufp_pkg::sm_to_twos({pay[5], pay[4]});
  assign long_ok = (pay24 == rufp_pkg::TailLong0) && (last_byte == rufp_pkg::TailLong1);

  always_comb begin
    if (kind == rufp_pkg::FrameLong) begin
      ok               = long_ok;
      res.frame_kind   = rufp_pkg::FrameLong;
      res.pos_x        = lx;
      res.pos_y        = ly;
      res.speed_tenths = ls;
      res.detected     = (lx != 16'd0) || (ly != 16'd0);
    end else begin
      ok               = short_ok;
      res.frame_kind   = rufp_pkg::FrameShort;
      res.pos_x        = w1 - cfg.origin_x;
      res.pos_y        = w2 - cfg.origin_y;
      res.speed_tenths = 16'sd0;
      res.detected     = 1'b1;
    end
  end

endmodule
